FILE: rtl/egpa_pkg.sv
// ----------------------------------------------------------------------------
// egpa_pkg: shared constants and elaboration-time functions
// Holds register indexes, fixed widths, and the constant functions that build
// the log2 table and the root constants of the exposure/gamma pipeline.
// ----------------------------------------------------------------------------
package egpa_pkg;

    localparam int CHAN_W  = 8;
    localparam int EXPO_W  = 13;
    localparam int OFFS_W  = 17;
    localparam int GAMMA_W = 16;
    localparam int RECIP_W = 23;
    localparam int CFG_W   = 17;
    localparam int ADDR_W  = 2;
    localparam int Q       = 30;

    localparam logic [ADDR_W-1:0] REG_EXPOSURE = 2'd0;
    localparam logic [ADDR_W-1:0] REG_OFFSET   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_GAMMA    = 2'd2;

    // Integer square root of a 64-bit value, bit by bit.
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 64'd0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q30.
    function automatic logic [30:0] root_q30(input int k);
        logic [63:0] r;
        r = 64'd2 << Q;
        for (int j = 1; j <= k; j++) r = isqrt64(r << Q);
        return r[30:0];
    endfunction

    // log2(v) with fb fraction bits, by repeated squaring of a Q30 mantissa.
    function automatic logic [63:0] log2_fixed(input int v, input int fb);
        int          n;
        logic [63:0] m;
        logic [63:0] res;
        n = 0;
        while ((v >> (n + 1)) != 0) n++;
        m   = 64'(v) << (Q - n);
        res = 64'(n) << fb;
        for (int k = fb - 1; k >= 0; k--) begin
            m = (m * m) >> Q;
            if (m >= (64'd2 << Q)) begin
                m   = m >> 1;
                res = res | (64'd1 << k);
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/exposure_gamma_pixel_adjust_top.sv
// ----------------------------------------------------------------------------
// exposure_gamma_pixel_adjust_top: exposure, offset and gamma for RGB pixels
// One item per cycle while the output is not stalled and the gamma divider is idle.
// Each stage holds under backpressure, and bubbles are squeezed out.
// Reset clears all valid bits and loads exposure 0, offset 0, gamma 1.0.
// A gamma write starts the reciprocal divider; s_tready is low in the
// write cycle and while the divider runs.
// ----------------------------------------------------------------------------
module exposure_gamma_pixel_adjust_top #(
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // red_in, green_in, blue_in
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // red_out, green_out, blue_out
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [egpa_pkg::ADDR_W-1:0]     cfg_addr,
    input  logic [egpa_pkg::CFG_W-1:0]      cfg_wdata
);
    import egpa_pkg::*;

    // One stage for the table, two for the log scaling, one per fraction
    // bit of the exp2 chain, and three for scale, shift and offset.
    localparam int NST = LOG_FRAC_BITS + 6;

    logic [EXPO_W-1:0]  expo_reg;
    logic [OFFS_W-1:0]  offs_reg;
    logic               gamma_start;
    logic [RECIP_W-1:0] recip;
    logic               div_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expo_reg <= '0;
            offs_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_EXPOSURE: expo_reg <= cfg_wdata[EXPO_W-1:0];
                REG_OFFSET:   offs_reg <= cfg_wdata[OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    assign gamma_start = cfg_we && (cfg_addr == REG_GAMMA);

    egpa_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gamma_start),
        .gamma   (cfg_wdata[GAMMA_W-1:0]),
        .recip   (recip),
        .busy    (div_busy)
    );

    // A stage may load when it is empty or when the stage after it moves,
    // so a stalled output only holds up as many stages as are full.
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = ~vld_reg[NST-1] | m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = ~vld_reg[i] | en[i+1];
        end
    end

    // New items wait while the gamma reciprocal is being worked out, and no
    // item is taken while reset is held.
    assign s_tready = aresetn & en[0] & ~div_busy & ~gamma_start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid & s_tready;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Three identical channel datapaths share the stage enables.
    for (genvar c = 0; c < 3; c++) begin : g_chan
        egpa_chan #(
            .LOG_FRAC_BITS (LOG_FRAC_BITS)
        ) u_chan (
            .aclk  (aclk),
            .en    (en),
            .v_in  (s_tdata[c*CHAN_W +: CHAN_W]),
            .expo  (expo_reg),
            .offs  (offs_reg),
            .recip (recip),
            .v_out (m_tdata[c*CHAN_W +: CHAN_W])
        );
    end

    assign m_tvalid = vld_reg[NST-1];

endmodule

FILE: rtl/egpa_recip.sv
// ----------------------------------------------------------------------------
// egpa_recip: reciprocal of gamma
// Restoring divider that forms round(2^28 / max(gamma, 41)), one quotient bit
// per cycle, after each write of the gamma register.
// ----------------------------------------------------------------------------
module egpa_recip (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [egpa_pkg::GAMMA_W-1:0]    gamma,
    output logic [egpa_pkg::RECIP_W-1:0]    recip,
    output logic                            busy
);
    import egpa_pkg::*;

    localparam int NUM_W = 29;
    localparam int REM_W = GAMMA_W + 1;
    localparam logic [GAMMA_W-1:0] GAMMA_MIN = 16'd41;

    logic                 busy_reg;
    logic [4:0]           cnt_reg,  cnt_next;
    logic [NUM_W-1:0]     num_reg,  num_next;
    logic [REM_W-1:0]     rem_reg,  rem_next;
    logic [NUM_W-1:0]     quo_reg,  quo_next;
    logic [GAMMA_W-1:0]   div_reg,  div_next;
    logic [RECIP_W-1:0]   recip_reg, recip_next;
    logic [GAMMA_W-1:0]   g;
    logic [REM_W-1:0]     trial;

    assign g = (gamma < GAMMA_MIN) ? GAMMA_MIN : gamma;
    assign trial = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};

    always_comb begin
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        recip_next = recip_reg;
        if (start) begin
            div_next = g;
            num_next = (NUM_W'(1) << 28) + NUM_W'(g >> 1);
            rem_next = '0;
            quo_next = '0;
            cnt_next = 5'(NUM_W);
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            if (trial >= REM_W'(div_reg)) begin
                rem_next = trial - REM_W'(div_reg);
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                recip_next = quo_next[RECIP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            recip_reg <= RECIP_W'(65536);
        end else begin
            busy_reg  <= start | (busy_reg & (cnt_reg != 5'd1));
            cnt_reg   <= cnt_next;
            recip_reg <= recip_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign recip = recip_reg;
    assign busy  = busy_reg;

endmodule

FILE: rtl/egpa_chan.sv
// ----------------------------------------------------------------------------
// egpa_chan: datapath of one colour channel
// Table log2, scaling by the gamma reciprocal, exposure add, exp2 by a chain
// of root multiplies, final scale, shift, offset and clamp.
// ----------------------------------------------------------------------------
module egpa_chan #(
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic [LOG_FRAC_BITS+5:0]            en,
    input  logic [egpa_pkg::CHAN_W-1:0]         v_in,
    input  logic [egpa_pkg::EXPO_W-1:0]         expo,
    input  logic [egpa_pkg::OFFS_W-1:0]         offs,
    input  logic [egpa_pkg::RECIP_W-1:0]        recip,
    output logic [egpa_pkg::CHAN_W-1:0]         v_out
);
    import egpa_pkg::*;

    localparam int FB   = LOG_FRAC_BITS;
    localparam int MW   = FB + 3;
    localparam int LW   = MW + 12;
    localparam int HW   = MW + 11;
    localparam int SW   = MW + 24;
    localparam int TW   = FB + 12;
    localparam int NW   = 12;
    localparam int BW   = 47;
    localparam int YW   = 41;
    localparam int ST_B = FB + 3;
    localparam int ST_H = FB + 4;
    localparam int ST_O = FB + 5;

    typedef logic [MW-1:0] mag_tab_t [256];

    function automatic mag_tab_t make_tab();
        mag_tab_t    tab;
        logic [63:0] lr;
        logic [63:0] lv;
        lr = log2_fixed(255, FB);
        tab[0] = '0;
        for (int i = 1; i < 256; i++) begin
            lv = log2_fixed(i, FB);
            tab[i] = (lv > lr) ? MW'(0) : MW'(lr - lv);
        end
        return tab;
    endfunction

    localparam mag_tab_t MAG_TAB = make_tab();

    // Stage 1: distance below full scale in log2.
    logic [MW-1:0]  s1_mag_reg;
    logic           s1_zero_reg;
    // Stage 2: partial products with the reciprocal.
    logic [LW-1:0]  s2_lo_reg;
    logic [HW-1:0]  s2_hi_reg;
    logic           s2_zero_reg;
    // Stage 3: exponent split into integer and fraction.
    logic [NW-1:0]  s3_n_reg;
    logic [FB-1:0]  s3_frac_reg;
    logic           s3_zero_reg;

    logic [SW-1:0]  sum;
    logic [MW+7:0]  smag;
    logic [TW-1:0]  expo_ext;
    logic [TW-1:0]  t;

    assign sum      = SW'(s2_lo_reg) + (SW'(s2_hi_reg) << 12) + SW'(32768);
    assign smag     = sum[SW-1:16];
    assign expo_ext = {{(TW-EXPO_W){expo[EXPO_W-1]}}, expo};
    assign t        = (expo_ext << (FB - 8)) - TW'(smag);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_mag_reg  <= MAG_TAB[v_in];
            s1_zero_reg <= (v_in == '0);
        end
        if (en[1]) begin
            s2_lo_reg   <= LW'(s1_mag_reg) * LW'(recip[11:0]);
            s2_hi_reg   <= HW'(s1_mag_reg) * HW'(recip[RECIP_W-1:12]);
            s2_zero_reg <= s1_zero_reg;
        end
        if (en[2]) begin
            s3_n_reg    <= t[TW-1:FB];
            s3_frac_reg <= t[FB-1:0];
            s3_zero_reg <= s2_zero_reg;
        end
    end

    // Exp2 chain: stage k multiplies by 2^(2^-k) when fraction bit FB-k is set.
    logic [30:0]    e_p_reg    [FB];
    logic [NW-1:0]  e_n_reg    [FB];
    logic [FB-1:0]  e_frac_reg [FB];
    logic           e_zero_reg [FB];

    for (genvar k = 1; k <= FB; k++) begin : g_exp
        localparam logic [30:0] ROOT = root_q30(k);
        logic [30:0]   p_in;
        logic [NW-1:0] n_in;
        logic [FB-1:0] f_in;
        logic          z_in;
        logic [61:0]   prod;
        if (k == 1) begin : g_first
            assign p_in = 31'd1 << Q;
            assign n_in = s3_n_reg;
            assign f_in = s3_frac_reg;
            assign z_in = s3_zero_reg;
        end else begin : g_next
            assign p_in = e_p_reg[k-2];
            assign n_in = e_n_reg[k-2];
            assign f_in = e_frac_reg[k-2];
            assign z_in = e_zero_reg[k-2];
        end
        assign prod = 62'(p_in) * 62'(ROOT);
        always_ff @(posedge aclk) begin
            if (en[k+2]) begin
                e_p_reg[k-1]    <= f_in[FB-k] ? prod[Q+30:Q] : p_in;
                e_n_reg[k-1]    <= n_in;
                e_frac_reg[k-1] <= f_in;
                e_zero_reg[k-1] <= z_in;
            end
        end
    end

    // Scale to full range, apply the integer exponent, add offset.
    logic [BW-1:0]     b_base_reg;
    logic [NW-1:0]     b_n_reg;
    logic              b_zero_reg;
    logic [YW-1:0]     h_y_reg;
    logic [CHAN_W-1:0] o_out_reg;

    logic [YW-1:0]          y_next;
    logic [61:0]            lsh;
    logic signed [NW:0]     rs;
    logic [BW-1:0]          rsh;
    logic signed [YW+1:0]   osum;
    logic [CHAN_W-1:0]      out_next;

    assign lsh = 62'(b_base_reg) << b_n_reg[3:0];
    assign rs  = 13'sd30 - $signed({b_n_reg[NW-1], b_n_reg});
    assign rsh = b_base_reg >> rs[5:0];

    always_comb begin
        if (b_zero_reg) begin
            y_next = '0;
        end else if (!b_n_reg[NW-1] && (b_n_reg >= NW'(16))) begin
            y_next = YW'(1) << 40;
        end else if (!b_n_reg[NW-1]) begin
            y_next = YW'(lsh >> Q);
        end else if (rs > 13'sd63) begin
            y_next = '0;
        end else begin
            y_next = YW'(rsh);
        end
    end

    always_comb begin
        osum = $signed({2'b00, h_y_reg}) + $signed({{(YW+2-OFFS_W){offs[OFFS_W-1]}}, offs});
        if (osum < 0) begin
            out_next = '0;
        end else if (osum > 43'sd65280) begin
            out_next = 8'd255;
        end else begin
            out_next = osum[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_B]) begin
            b_base_reg <= BW'(e_p_reg[FB-1]) * BW'(16'd65280);
            b_n_reg    <= e_n_reg[FB-1];
            b_zero_reg <= e_zero_reg[FB-1];
        end
        if (en[ST_H]) begin
            h_y_reg <= y_next;
        end
        if (en[ST_O]) begin
            o_out_reg <= out_next;
        end
    end

    assign v_out = o_out_reg;

endmodule
